@@ src/bdr_pkg.sv @@
// Shared types, protocol codes and response builder for the boot download responder.
`default_nettype none
package bdr_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int HDR_BYTES   = 16;

    localparam logic [7:0] PROTO_CTRL_REQ   = 8'h53;
    localparam logic [7:0] PROTO_CTRL_RSP   = 8'h73;
    localparam logic [7:0] CTRL_CONNECT     = 8'h43;
    localparam logic [7:0] CTRL_ACK_CONNECT = 8'h63;
    localparam logic [7:0] PROTO_LOAD_REQ   = 8'h54;
    localparam logic [7:0] PROTO_LOAD_RSP   = 8'h74;
    localparam logic [7:0] LOAD_APPTYPE     = 8'h42;

    localparam logic [7:0] MODE_DL_FLASH    = 8'h01;
    localparam logic [7:0] MODE_RUN_FLASH   = 8'h02;
    localparam logic [7:0] MODE_RUN_RAM     = 8'h04;
    localparam logic [7:0] MODE_DL_BOOT     = 8'h05;
    localparam logic [7:0] MODE_RESET_FLASH = 8'h06;
    localparam logic [7:0] MODE_MAC         = 8'h0F;

    localparam logic [31:0] MAX_RX_SIZE = 32'(1024 * 1024);
    localparam logic [15:0] SEQ_END     = 16'hFFFF;

    localparam logic [7:0] ERR_NONE     = 8'd0;
    localparam logic [7:0] ERR_CHECKSUM = 8'd3;
    localparam logic [7:0] ERR_MODE     = 8'd5;

    localparam logic [7:0] CONN_RETRY0  = 8'd5;
    localparam logic [7:0] CONN_RETRY1  = 8'd4;
    localparam logic [7:0] CONN_TIMER0  = 8'd6;
    localparam logic [7:0] CONN_TIMER1  = 8'd0;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CHECKSUM = 2'd1;
    localparam logic [1:0] ST_MODE     = 2'd2;

    typedef logic [HDR_BYTES-1:0][7:0] t_hdr;

    typedef struct packed {
        t_hdr       bytes;
        logic [1:0] status;
    } t_resp;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    function automatic t_resp build_resp(input t_hdr hdr, input logic [31:0] sum);
        t_resp       rsp;
        logic [7:0]  err;
        logic [15:0] seq;
        logic [31:0] chk;
        rsp.bytes  = hdr;
        rsp.status = ST_OK;
        err        = ERR_NONE;
        seq        = {hdr[6], hdr[7]};
        chk        = {hdr[12], hdr[13], hdr[14], hdr[15]};
        if (hdr[0] == PROTO_CTRL_REQ) begin
            rsp.bytes[0]  = PROTO_CTRL_RSP;
            rsp.bytes[2]  = 8'd0;
            rsp.bytes[3]  = 8'd0;
            rsp.bytes[12] = 8'd0;
            rsp.bytes[13] = 8'd0;
            rsp.bytes[14] = 8'd0;
            rsp.bytes[15] = 8'd0;
            if (hdr[1] == CTRL_CONNECT) begin
                rsp.bytes[1]  = CTRL_ACK_CONNECT;
                rsp.bytes[4]  = CONN_RETRY0;
                rsp.bytes[5]  = CONN_RETRY1;
                rsp.bytes[6]  = CONN_TIMER0;
                rsp.bytes[7]  = CONN_TIMER1;
                rsp.bytes[8]  = MAX_RX_SIZE[31:24];
                rsp.bytes[9]  = MAX_RX_SIZE[23:16];
                rsp.bytes[10] = MAX_RX_SIZE[15:8];
                rsp.bytes[11] = MAX_RX_SIZE[7:0];
            end
        end else if (hdr[0] == PROTO_LOAD_REQ) begin
            rsp.bytes[12] = 8'd0;
            rsp.bytes[13] = 8'd0;
            rsp.bytes[14] = 8'd0;
            rsp.bytes[15] = 8'd0;
            if (hdr[1] == LOAD_APPTYPE) begin
                unique case (hdr[3]) inside
                    MODE_RESET_FLASH, MODE_RUN_FLASH, MODE_RUN_RAM, MODE_MAC: begin
                        err = ERR_NONE;
                    end
                    MODE_DL_FLASH, MODE_DL_BOOT: begin
                        if (seq == SEQ_END) begin
                            if (sum != chk) begin
                                err        = ERR_CHECKSUM;
                                rsp.status = ST_CHECKSUM;
                            end else begin
                                rsp.bytes[12] = sum[31:24];
                                rsp.bytes[13] = sum[23:16];
                                rsp.bytes[14] = sum[15:8];
                                rsp.bytes[15] = sum[7:0];
                            end
                        end
                    end
                    default: begin
                        err        = ERR_MODE;
                        rsp.status = ST_MODE;
                    end
                endcase
            end
            rsp.bytes[0]  = PROTO_LOAD_RSP;
            rsp.bytes[4]  = 8'd0;
            rsp.bytes[5]  = err;
            rsp.bytes[8]  = 8'd0;
            rsp.bytes[9]  = 8'd0;
            rsp.bytes[10] = 8'd0;
            rsp.bytes[11] = 8'd0;
        end
        return rsp;
    endfunction

endpackage
`default_nettype wire

@@ src/bdr_front.sv @@
// Request parser: header capture, payload count, download sum and response build.
`default_nettype none
module bdr_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_rx_valid,
    input  wire logic [7:0]     i_rx_byte,
    output logic                o_rx_stall,
    input  wire bdr_pkg::t_q_status i_q_stat,
    output logic                o_push,
    output bdr_pkg::t_resp      o_push_data
);
    import bdr_pkg::*;

    t_hdr        r_hdr;
    logic [3:0]  r_idx,     n_idx;
    logic [31:0] r_left,    n_left;
    logic        r_in_pay,  n_in_pay;
    logic [15:0] r_session, n_session;
    logic [31:0] r_sum,     n_sum;

    t_hdr        w_hdr;
    logic [31:0] w_len;
    logic [31:0] w_sum_resp;
    logic        w_dl;
    logic        w_hdr_done;
    logic        w_fire;
    logic        w_acc;

    always_comb begin
        w_hdr = r_hdr;
        if (!r_in_pay) begin
            w_hdr[HDR_BYTES-1] = i_rx_byte;
        end
    end

    assign w_len      = {r_hdr[8], r_hdr[9], r_hdr[10], r_hdr[11]};
    assign w_dl       = (r_hdr[0] == PROTO_LOAD_REQ) && (r_hdr[1] == LOAD_APPTYPE) &&
                        ((r_hdr[3] == MODE_DL_FLASH) || (r_hdr[3] == MODE_DL_BOOT));
    assign w_hdr_done = !r_in_pay && (r_idx == 4'(HDR_BYTES - 1));
    assign w_fire     = w_hdr_done ? (w_len == 32'd0) : (r_in_pay && (r_left == 32'd1));
    assign o_rx_stall = i_q_stat.full && w_fire;
    assign w_acc      = i_rx_valid && !o_rx_stall;

    always_comb begin
        if (w_hdr_done) begin
            w_sum_resp = (w_dl && (r_session == 16'd0)) ? 32'd0 : r_sum;
        end else begin
            w_sum_resp = r_sum + (w_dl ? {24'd0, i_rx_byte} : 32'd0);
        end
    end

    assign o_push      = w_acc && w_fire;
    assign o_push_data = build_resp(w_hdr, w_sum_resp);

    always_comb begin
        n_idx     = r_idx;
        n_left    = r_left;
        n_in_pay  = r_in_pay;
        n_session = r_session;
        n_sum     = r_sum;
        if (w_acc) begin
            if (!r_in_pay) begin
                n_idx = r_idx + 4'd1;
            end
            if (w_hdr_done) begin
                n_left   = w_len;
                n_in_pay = (w_len != 32'd0);
                n_sum    = w_sum_resp;
            end else if (r_in_pay) begin
                n_left = r_left - 32'd1;
                n_sum  = w_sum_resp;
                if (r_left == 32'd1) begin
                    n_in_pay = 1'b0;
                end
            end
            if (w_fire && w_dl) begin
                n_session = ({r_hdr[6], r_hdr[7]} == SEQ_END) ? 16'd0 : r_session + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_left    <= '0;
            r_in_pay  <= 1'b0;
            r_session <= '0;
            r_sum     <= '0;
        end else begin
            r_idx     <= n_idx;
            r_left    <= n_left;
            r_in_pay  <= n_in_pay;
            r_session <= n_session;
            r_sum     <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && !r_in_pay) begin
            r_hdr[r_idx] <= i_rx_byte;
        end
    end

endmodule
`default_nettype wire

@@ src/bdr_queue.sv @@
// Short response queue between parser and serializer.
`default_nettype none
module bdr_queue #(
    parameter int QUEUE_DEPTH = bdr_pkg::QUEUE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire bdr_pkg::t_resp     i_push_data,
    input  wire logic               i_pop,
    output bdr_pkg::t_resp          o_head,
    output bdr_pkg::t_q_status      o_stat
);
    import bdr_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_resp          r_mem [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_head       = r_mem[r_rd];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == CW'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= bump(r_wr);
            end
            if (i_pop) begin
                r_rd <= bump(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

@@ src/bdr_back.sv @@
// Response serializer: sends each queued response as 16 words from an output register.
`default_nettype none
module bdr_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bdr_pkg::t_resp     i_head,
    input  wire bdr_pkg::t_q_status i_q_stat,
    output logic                    o_pop,
    output logic                    o_resp_valid,
    input  wire logic               i_resp_stall,
    output logic [7:0]              o_resp_byte,
    output logic                    o_resp_last,
    output logic [1:0]              o_status_code
);
    import bdr_pkg::*;

    logic       r_valid;
    logic [3:0] r_pos;
    logic [7:0] r_byte;
    logic       r_last;
    logic [1:0] r_status;
    logic       w_load;
    logic       w_end;

    assign w_end  = (r_pos == 4'(HDR_BYTES - 1));
    assign w_load = !i_q_stat.empty && (!r_valid || !i_resp_stall);
    assign o_pop  = w_load && w_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_pos   <= r_pos + 4'd1;
            end else if (!i_resp_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte   <= i_head.bytes[r_pos];
            r_last   <= w_end;
            r_status <= i_head.status;
        end
    end

    assign o_resp_valid  = r_valid;
    assign o_resp_byte   = r_byte;
    assign o_resp_last   = r_last;
    assign o_status_code = r_status;

endmodule
`default_nettype wire

@@ src/boot_download_responder_unit.sv @@
// Boot download responder: top level joining parser, response queue and serializer.
// Takes one request word per cycle unless the parser stalls; a packet's response is
// queued when its last word is accepted and then fed word by word to the serializer.
// Each response is 16 words, one per cycle unless stalled, from its output register.
// The parser stalls only on a packet's last word while the response queue is full.
// Synchronous active-low reset clears parser counters, download session and queue.
`default_nettype none
module boot_download_responder_unit #(
    parameter int QUEUE_DEPTH = bdr_pkg::QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_rx_valid,
    output logic            o_rx_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_resp_valid,
    input  wire logic       i_resp_stall,
    output logic [7:0]      o_resp_byte,
    output logic            o_resp_last,
    output logic [1:0]      o_status_code
);
    import bdr_pkg::*;

    t_q_status q_stat;
    t_resp     push_data;
    t_resp     head;
    logic      push;
    logic      pop;

    bdr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .i_rx_byte   (i_rx_byte),
        .o_rx_stall  (o_rx_stall),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_data (push_data)
    );

    bdr_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_stat      (q_stat)
    );

    bdr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .o_resp_valid  (o_resp_valid),
        .i_resp_stall  (i_resp_stall),
        .o_resp_byte   (o_resp_byte),
        .o_resp_last   (o_resp_last),
        .o_status_code (o_status_code)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("push into full response queue");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> q_stat.full)
        else $error("request stalled with queue space free");

    a_resp_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_resp_valid && !i_resp_stall && !o_resp_last) |=> o_resp_valid)
        else $error("gap inside a response");

    a_status_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_resp_valid && !i_resp_stall && !o_resp_last) |=>
            (o_status_code == $past(o_status_code)))
        else $error("status changed inside a response");

endmodule
`default_nettype wire

@@ bench/tb_boot_download_responder_unit.sv @@
// Self-checking testbench for the boot download responder: directed and random packets.
`timescale 1ns / 100ps
module tb_boot_download_responder_unit;
    import bdr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 32;
    localparam logic [7:0] GOOD_MODES [4] = '{MODE_RUN_FLASH, MODE_RUN_RAM,
                                              MODE_RESET_FLASH, MODE_MAC};
    localparam logic [7:0] BAD_MODES [3] = '{8'h00, 8'h03, 8'hFF};
    localparam logic [7:0] ODD_PROTOS [3] = '{8'h00, 8'hFF, 8'h73};

    typedef logic [7:0] hdr_t [16];
    typedef logic [7:0] byte_q_t [$];
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] status;
    } resp_word_t;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_rx_valid;
    logic       o_rx_stall;
    logic [7:0] i_rx_byte;
    logic       o_resp_valid;
    logic       i_resp_stall;
    logic [7:0] o_resp_byte;
    logic       o_resp_last;
    logic [1:0] o_status_code;

    boot_download_responder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (i_rx_valid),
        .o_rx_stall    (o_rx_stall),
        .i_rx_byte     (i_rx_byte),
        .o_resp_valid  (o_resp_valid),
        .i_resp_stall  (i_resp_stall),
        .o_resp_byte   (o_resp_byte),
        .o_resp_last   (o_resp_last),
        .o_status_code (o_status_code)
    );

    // request parser state mirrored by the predictor
    logic [7:0]  hdr_seen [16];
    logic [4:0]  hdr_count   = '0;
    logic [31:0] body_left   = '0;
    bit          in_body     = 1'b0;
    logic [15:0] session_pkts = '0;
    logic [31:0] session_sum = '0;

    resp_word_t expected_resp [$];

    bit tx_gaps = 1'b1;
    bit rx_stalls = 1'b1;
    int stall_left = 0;
    int idle_cycles = 0;
    int fail_count = 0;
    int words_sent = 0;
    int packets_sent = 0;
    int resp_words = 0;
    int sessions_closed = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit is_download();
        return hdr_seen[0] == PROTO_LOAD_REQ && hdr_seen[1] == LOAD_APPTYPE &&
               (hdr_seen[3] == MODE_DL_FLASH || hdr_seen[3] == MODE_DL_BOOT);
    endfunction

    task automatic queue_response();
        logic [7:0]  r [16];
        logic [1:0]  st;
        logic [7:0]  err;
        logic [15:0] seq;
        logic [31:0] chk;
        resp_word_t  w;
        r   = hdr_seen;
        st  = ST_OK;
        err = ERR_NONE;
        seq = {hdr_seen[6], hdr_seen[7]};
        chk = {hdr_seen[12], hdr_seen[13], hdr_seen[14], hdr_seen[15]};
        if (hdr_seen[0] == PROTO_CTRL_REQ) begin
            r[0] = PROTO_CTRL_RSP;
            r[2] = 8'd0;
            r[3] = 8'd0;
            {r[12], r[13], r[14], r[15]} = 32'd0;
            if (hdr_seen[1] == CTRL_CONNECT) begin
                r[1] = CTRL_ACK_CONNECT;
                {r[4], r[5], r[6], r[7]} = {CONN_RETRY0, CONN_RETRY1, CONN_TIMER0, CONN_TIMER1};
                {r[8], r[9], r[10], r[11]} = MAX_RX_SIZE;
            end
        end else if (hdr_seen[0] == PROTO_LOAD_REQ) begin
            {r[12], r[13], r[14], r[15]} = 32'd0;
            if (hdr_seen[1] == LOAD_APPTYPE) begin
                if (hdr_seen[3] == MODE_RESET_FLASH || hdr_seen[3] == MODE_RUN_FLASH ||
                    hdr_seen[3] == MODE_RUN_RAM || hdr_seen[3] == MODE_MAC) begin
                    err = ERR_NONE;
                end else if (hdr_seen[3] == MODE_DL_FLASH || hdr_seen[3] == MODE_DL_BOOT) begin
                    if (seq == SEQ_END) begin
                        session_pkts = '0;
                        sessions_closed++;
                        if (session_sum != chk) begin
                            err = ERR_CHECKSUM;
                            st  = ST_CHECKSUM;
                        end else begin
                            {r[12], r[13], r[14], r[15]} = session_sum;
                        end
                    end else begin
                        session_pkts = session_pkts + 16'd1;
                    end
                end else begin
                    err = ERR_MODE;
                    st  = ST_MODE;
                end
            end
            r[0] = PROTO_LOAD_RSP;
            {r[8], r[9], r[10], r[11]} = 32'd0;
            r[4] = 8'd0;
            r[5] = err;
        end
        for (int k = 0; k < 16; k++) begin
            w.data   = r[k];
            w.last   = (k == 15);
            w.status = st;
            expected_resp.push_back(w);
        end
    endtask

    task automatic absorb_word(input logic [7:0] b);
        if (!in_body) begin
            hdr_seen[hdr_count[3:0]] = b;
            hdr_count = hdr_count + 5'd1;
            if (hdr_count == 5'd16) begin
                hdr_count = '0;
                if (is_download() && session_pkts == 16'd0)
                    session_sum = '0;
                body_left = {hdr_seen[8], hdr_seen[9], hdr_seen[10], hdr_seen[11]};
                if (body_left == 32'd0)
                    queue_response();
                else
                    in_body = 1'b1;
            end
        end else begin
            if (is_download())
                session_sum = session_sum + 32'(b);
            body_left = body_left - 32'd1;
            if (body_left == 32'd0) begin
                in_body = 1'b0;
                queue_response();
            end
        end
    endtask

    task automatic send_word(input logic [7:0] b);
        int gap;
        if (tx_gaps && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 5);
            repeat (gap) begin
                @(negedge i_clk);
                i_rx_valid <= 1'b0;
                i_rx_byte  <= 8'($urandom);
            end
        end
        @(negedge i_clk);
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_rx_stall);
        absorb_word(b);
        words_sent++;
    endtask

    task automatic send_packet(input hdr_t h, input byte_q_t body);
        for (int i = 0; i < 16; i++)
            send_word(h[i]);
        foreach (body[i])
            send_word(body[i]);
        packets_sent++;
    endtask

    function automatic hdr_t make_hdr(input logic [7:0] proto, input logic [7:0] app,
                                      input logic [7:0] mode, input logic [15:0] seq,
                                      input logic [31:0] len, input logic [31:0] chk);
        hdr_t h;
        h[0] = proto;
        h[1] = app;
        h[2] = 8'($urandom);
        h[3] = mode;
        h[4] = 8'($urandom);
        h[5] = 8'($urandom);
        {h[6], h[7]} = seq;
        {h[8], h[9], h[10], h[11]} = len;
        {h[12], h[13], h[14], h[15]} = chk;
        return h;
    endfunction

    function automatic byte_q_t rand_body(input int n);
        byte_q_t q;
        for (int i = 0; i < n; i++)
            q.push_back(8'($urandom));
        return q;
    endfunction

    task automatic send_plain(input logic [7:0] proto, input logic [7:0] app,
                              input logic [7:0] mode, input int len);
        send_packet(make_hdr(proto, app, mode, 16'($urandom), len, $urandom), rand_body(len));
    endtask

    // checksum field carries the running session sum when good is set
    task automatic send_download(input logic [7:0] mode, input logic [15:0] seq,
                                 input int len, input bit good);
        byte_q_t     body;
        logic [31:0] sum;
        logic [31:0] chk;
        body = rand_body(len);
        sum  = (session_pkts == 16'd0) ? 32'd0 : session_sum;
        foreach (body[i])
            sum = sum + 32'(body[i]);
        chk = good ? sum : (sum ^ (32'($urandom) | 32'd1));
        send_packet(make_hdr(PROTO_LOAD_REQ, LOAD_APPTYPE, mode, seq, len, chk), body);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        while (expected_resp.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic test_control();
        send_plain(PROTO_CTRL_REQ, CTRL_CONNECT, 8'($urandom), 0);
    endtask

    task automatic test_load_modes();
        send_plain(PROTO_LOAD_REQ, LOAD_APPTYPE, GOOD_MODES[$urandom_range(0, 3)], 0);
        send_plain(PROTO_LOAD_REQ, LOAD_APPTYPE, BAD_MODES[$urandom_range(0, 2)], 0);
    endtask

    task automatic test_download_sessions();
        send_download(MODE_DL_FLASH, 16'($urandom_range(0, 16'hFFFE)), 2, 1'b1);
        wait_drained();
        send_download(MODE_DL_BOOT, SEQ_END, 1, 1'b1);
    endtask

    task automatic test_checksum_error();
        send_download(MODE_DL_FLASH, SEQ_END, 0, 1'b0);
    endtask

    task automatic test_echo();
        send_plain(ODD_PROTOS[$urandom_range(0, 2)], 8'($urandom), 8'($urandom), 0);
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_resp_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
            i_resp_stall <= 1'b1;
            stall_left   <= $urandom_range(0, 4);
        end else begin
            i_resp_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_resp
        resp_word_t w;
        if (i_rst_n && o_resp_valid && !i_resp_stall) begin
            if (expected_resp.size() == 0) begin
                $error("unexpected response word %h", o_resp_byte);
                fail_count++;
            end else begin
                w = expected_resp.pop_front();
                resp_words++;
                if (o_resp_byte !== w.data) begin
                    $error("resp_byte: expected %h, actual %h", w.data, o_resp_byte);
                    fail_count++;
                end
                if (o_resp_last !== w.last) begin
                    $error("resp_last: expected %b, actual %b", w.last, o_resp_last);
                    fail_count++;
                end
                if (o_status_code !== w.status) begin
                    $error("status_code: expected %0d, actual %0d", w.status, o_status_code);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_rx_valid && !o_rx_stall) || (o_resp_valid && !i_resp_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** boot_download_responder_unit: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_rx_valid   = 1'b0;
        i_rx_byte    = 8'd0;
        i_resp_stall = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_control();
        test_load_modes();
        test_download_sessions();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        test_checksum_error();
        test_echo();

        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        while (expected_resp.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d packets in %0d request words; checked %0d response words.",
                 packets_sent, words_sent, resp_words);
        $display("Connect, good and bad load modes, echoed id and %0d closed download sessions.",
                 sessions_closed);
        if (fail_count == 0) begin
            $display("** boot_download_responder_unit: PASSED **");
        end else begin
            $display("** boot_download_responder_unit: FAILED **");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/bdr_pkg.sv
src/bdr_front.sv
src/bdr_queue.sv
src/bdr_back.sv
src/boot_download_responder_unit.sv
bench/tb_boot_download_responder_unit.sv
